// File: sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge outside of reset
`define GSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every rising edge, reset included
`define GSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/gsa_pkg.sv
`default_nettype none

package gsa_pkg;

  // table geometry
  localparam int SlotCount = 128;
  localparam int SlotBits  = $clog2(SlotCount);
  localparam int GenBits   = 16;
  localparam int KeyBits   = 48;

  typedef logic [SlotBits-1:0] slot_t;
  typedef logic [GenBits-1:0]  gen_t;
  typedef logic [KeyBits-1:0]  key_t;

  localparam slot_t SlotNil = slot_t'(0);
  localparam slot_t SlotMax = slot_t'(SlotCount - 1);

  // operation codes
  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CHECK   = 2'd2,
    KIND_FIND    = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_STALE     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_e;

  // one result word
  typedef struct packed {
    status_e status;
    slot_t   slot;
    gen_t    gen;
    slot_t   live;
  } res_t;

endpackage

`default_nettype wire

// File: sv/generational_slot_allocator_unit.sv
// channel | dir | tuser      | tdata (lowest bit first)
// s_axis  | in  | kind [1:0] | slot_in[6:0] gen_in[22:7] ip_addr[54:23] port_num[70:55]
// m_axis  | out | status     | slot_out[6:0] gen_out[22:7] live_count[29:23]
//
// allocate, release and check: result word loaded after lookup, exec and done; a full alloc skips exec
// find scans slots 1 to 127 through the key memory read port, stopping at the first live key match
// one operation at a time; s_axis_tready is high only while the sequencer idles
// the result sits in an output register, a stalled m_axis holds the next operation
// reset clears occupancy, generation valid bits, free head and live count at once
`default_nettype none

`include "assert_macros.svh"

module generational_slot_allocator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [1:0]  s_axis_tuser_i,  // kind
  input  wire logic [71:0] s_axis_tdata_i,  // slot_in, gen_in, ip_addr, port_num, pad
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [1:0]       m_axis_tuser_o,  // status
  output logic [31:0]      m_axis_tdata_o   // slot_out, gen_out, live_count, pad
);

  gsa_pkg::state_e state_q, state_d;

  // captured operation
  gsa_pkg::kind_e kind_q;
  gsa_pkg::slot_t slot_q;
  gsa_pkg::gen_t  gen_q;
  gsa_pkg::key_t  key_q;

  // table control state
  logic [gsa_pkg::SlotCount-1:0] occ_q, occ_d;
  logic [gsa_pkg::SlotCount-1:0] gvld_q, gvld_d;
  gsa_pkg::slot_t head_q, head_d;
  gsa_pkg::slot_t count_q, count_d;

  // sequencer working registers
  gsa_pkg::slot_t addr_q, addr_d;
  gsa_pkg::slot_t scan_q, scan_d;
  logic           pop_q, pop_d;
  logic           cmp_vld_q, cmp_vld_d;
  gsa_pkg::res_t  res_q, res_d;

  // memories and their registered read data
  gsa_pkg::gen_t  gen_mem  [gsa_pkg::SlotCount];
  gsa_pkg::slot_t link_mem [gsa_pkg::SlotCount];
  gsa_pkg::key_t  key_mem  [gsa_pkg::SlotCount];
  gsa_pkg::gen_t  gen_rd_q;
  gsa_pkg::slot_t link_rd_q;
  gsa_pkg::key_t  key_rd_q;
  gsa_pkg::slot_t rd_addr, rd_addr_q;
  logic           gen_we, link_we, key_we;
  gsa_pkg::gen_t  gen_wdata;

  // output register
  logic           m_valid_q;
  gsa_pkg::res_t  m_res_q;
  logic           out_load;

  logic           s_accept;
  gsa_pkg::gen_t  gen_cur;
  logic           hit;
  logic [gsa_pkg::SlotBits:0] fresh;

  assign s_axis_tready_o = (state_q == gsa_pkg::ST_IDLE);
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;

  // generation of the last slot read, zero until first written
  assign gen_cur = gvld_q[rd_addr_q] ? gen_rd_q : gsa_pkg::gen_t'(0);
  assign hit     = (addr_q != gsa_pkg::SlotNil) && occ_q[addr_q] && (gen_cur == gen_q);
  assign fresh   = {1'b0, count_q} + (gsa_pkg::SlotBits+1)'(1);

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gsa_pkg::ST_IDLE;
      occ_q     <= '0;
      gvld_q    <= '0;
      head_q    <= gsa_pkg::SlotNil;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      gvld_q    <= gvld_d;
      head_q    <= head_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      kind_q <= gsa_pkg::kind_e'(s_axis_tuser_i);
      slot_q <= s_axis_tdata_i[6:0];
      gen_q  <= s_axis_tdata_i[22:7];
      key_q  <= {s_axis_tdata_i[70:55], s_axis_tdata_i[54:23]};
    end
    addr_q    <= addr_d;
    scan_q    <= scan_d;
    pop_q     <= pop_d;
    res_q     <= res_d;
    rd_addr_q <= rd_addr;
    if (out_load) begin
      m_res_q <= res_q;
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[addr_q] <= gen_wdata;
    end
    if (link_we) begin
      link_mem[addr_q] <= head_q;
    end
    if (key_we) begin
      key_mem[addr_q] <= key_q;
    end
    gen_rd_q  <= gen_mem[rd_addr];
    link_rd_q <= link_mem[rd_addr];
    key_rd_q  <= key_mem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    gvld_d    = gvld_q;
    head_d    = head_q;
    count_d   = count_q;
    addr_d    = addr_q;
    scan_d    = scan_q;
    pop_d     = pop_q;
    res_d     = res_q;
    cmp_vld_d = 1'b0;
    rd_addr   = addr_q;
    gen_we    = 1'b0;
    link_we   = 1'b0;
    key_we    = 1'b0;
    gen_wdata = gen_cur + gsa_pkg::gen_t'(1);
    out_load  = 1'b0;
    unique case (state_q)
      gsa_pkg::ST_IDLE: begin
        if (s_accept) begin
          state_d = gsa_pkg::ST_LOOKUP;
        end
      end
      gsa_pkg::ST_LOOKUP: begin
        state_d = gsa_pkg::ST_EXEC;
        unique case (kind_q)
          gsa_pkg::KIND_ALLOC: begin
            // free list first, then the next fresh slot
            if (head_q != gsa_pkg::SlotNil) begin
              addr_d = head_q;
              pop_d  = 1'b1;
            end else if (fresh < (gsa_pkg::SlotBits+1)'(gsa_pkg::SlotCount)) begin
              addr_d = fresh[gsa_pkg::SlotBits-1:0];
              pop_d  = 1'b0;
            end else begin
              res_d   = '{gsa_pkg::STAT_FULL, gsa_pkg::SlotNil, '0, count_q};
              state_d = gsa_pkg::ST_DONE;
            end
          end
          gsa_pkg::KIND_RELEASE, gsa_pkg::KIND_CHECK: begin
            addr_d = slot_q;
          end
          gsa_pkg::KIND_FIND: begin
            scan_d  = gsa_pkg::slot_t'(1);
            state_d = gsa_pkg::ST_SCAN;
          end
        endcase
        rd_addr = addr_d;
      end
      gsa_pkg::ST_EXEC: begin
        state_d = gsa_pkg::ST_DONE;
        unique case (kind_q)
          gsa_pkg::KIND_ALLOC: begin
            gen_we         = 1'b1;
            key_we         = 1'b1;
            occ_d[addr_q]  = 1'b1;
            gvld_d[addr_q] = 1'b1;
            count_d        = count_q + gsa_pkg::slot_t'(1);
            if (pop_q) begin
              head_d = link_rd_q;
            end
            res_d = '{gsa_pkg::STAT_OK, addr_q, gen_wdata, count_d};
          end
          gsa_pkg::KIND_RELEASE: begin
            if (hit) begin
              occ_d[addr_q] = 1'b0;
              if (count_q != '0) begin
                count_d = count_q - gsa_pkg::slot_t'(1);
              end
              link_we = 1'b1;
              head_d  = addr_q;
              res_d   = '{gsa_pkg::STAT_OK, gsa_pkg::SlotNil, '0, count_d};
            end else begin
              res_d = '{gsa_pkg::STAT_STALE, gsa_pkg::SlotNil, '0, count_q};
            end
          end
          gsa_pkg::KIND_CHECK: begin
            if (hit) begin
              res_d = '{gsa_pkg::STAT_OK, addr_q, gen_cur, count_q};
            end else begin
              res_d = '{gsa_pkg::STAT_STALE, gsa_pkg::SlotNil, '0, count_q};
            end
          end
          gsa_pkg::KIND_FIND: begin
            res_d = '{gsa_pkg::STAT_NOT_FOUND, gsa_pkg::SlotNil, '0, count_q};
          end
        endcase
      end
      gsa_pkg::ST_SCAN: begin
        // issue the next key read while comparing the previous one
        rd_addr   = scan_q;
        cmp_vld_d = 1'b1;
        if (scan_q != gsa_pkg::SlotMax) begin
          scan_d = scan_q + gsa_pkg::slot_t'(1);
        end
        if (cmp_vld_q && occ_q[rd_addr_q] && (key_rd_q == key_q)) begin
          res_d     = '{gsa_pkg::STAT_OK, rd_addr_q, gen_cur, count_q};
          cmp_vld_d = 1'b0;
          state_d   = gsa_pkg::ST_DONE;
        end else if (cmp_vld_q && (rd_addr_q == gsa_pkg::SlotMax)) begin
          res_d     = '{gsa_pkg::STAT_NOT_FOUND, gsa_pkg::SlotNil, '0, count_q};
          cmp_vld_d = 1'b0;
          state_d   = gsa_pkg::ST_DONE;
        end
      end
      gsa_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = gsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gsa_pkg::ST_IDLE;
      end
    endcase
  end

  // output word
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_res_q.status;
  assign m_axis_tdata_o  = {2'b00, m_res_q.live, m_res_q.gen, m_res_q.slot};

  // the nil slot is never handed out
  `GSA_ASSERT(a_nil_free, !occ_q[0], "nil slot marked occupied")
  // free list head always names a released slot
  `GSA_ASSERT(a_head_free, (head_q != gsa_pkg::SlotNil) |-> !occ_q[head_q], "free head occupied")
  // live count tracks the occupancy flags
  `GSA_ASSERT_ALWAYS(a_count, !rst_ni || ($countones(occ_q) == int'(count_q)),
                     "live count out of step with occupancy")
  // an accepted word always starts with the lookup step
  `GSA_ASSERT(a_start, s_accept |=> (state_q == gsa_pkg::ST_LOOKUP), "accept did not start lookup")

endmodule

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

import gsa_pkg::*;

// slot table scoreboard: tracks the expected table contents and queues expected words
class slot_table_sb;
  bit          busy    [SlotCount];
  gen_t        gen_of  [SlotCount];
  slot_t       link_of [SlotCount];
  logic [31:0] ip_of   [SlotCount];
  logic [15:0] port_of [SlotCount];
  slot_t       head;
  slot_t       live;
  res_t        expected_q [$];
  res_t        last;
  int          errors;

  function new();
    foreach (busy[i]) begin
      busy[i]    = 1'b0;
      gen_of[i]  = '0;
      link_of[i] = SlotNil;
      ip_of[i]   = '0;
      port_of[i] = '0;
    end
    head   = SlotNil;
    live   = '0;
    errors = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function bit handle_ok(slot_t s, gen_t g);
    return s != SlotNil && busy[s] && gen_of[s] == g;
  endfunction

  // apply one accepted request word to the table and queue its result word
  function void note_request(kind_e k, slot_t s, gen_t g, logic [31:0] ip,
                             logic [15:0] port);
    res_t  r;
    slot_t pick;
    r.status = STAT_OK;
    r.slot   = SlotNil;
    r.gen    = '0;
    pick     = SlotNil;
    case (k)
      KIND_ALLOC: begin
        // lifo free list first, then the next fresh slot
        if (head != SlotNil) begin
          pick = head;
          head = link_of[pick];
        end else if (int'(live) + 1 < SlotCount) begin
          pick = slot_t'(live + 1);
        end else begin
          r.status = STAT_FULL;
        end
        if (pick != SlotNil) begin
          ip_of[pick]   = ip;
          port_of[pick] = port;
          busy[pick]    = 1'b1;
          gen_of[pick]  = gen_of[pick] + 1'b1;
          live          = live + 1'b1;
          r.slot        = pick;
          r.gen         = gen_of[pick];
        end
      end
      KIND_RELEASE: begin
        if (!handle_ok(s, g)) begin
          r.status = STAT_STALE;
        end else begin
          busy[s] = 1'b0;
          if (live != '0) live = live - 1'b1;
          link_of[s] = head;
          head       = s;
        end
      end
      KIND_CHECK: begin
        if (!handle_ok(s, g)) begin
          r.status = STAT_STALE;
        end else begin
          r.slot = s;
          r.gen  = gen_of[s];
        end
      end
      default: begin
        // first live slot with a matching key, scanning upward
        r.status = STAT_NOT_FOUND;
        for (int i = 1; i < SlotCount; i++) begin
          if (busy[i] && ip_of[i] == ip && port_of[i] == port) begin
            r.status = STAT_OK;
            r.slot   = slot_t'(i);
            r.gen    = gen_of[i];
            break;
          end
        end
      end
    endcase
    r.live = live;
    last   = r;
    expected_q.push_back(r);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 100) $display("mismatch: %s", msg);
  endtask

  // compare one accepted result word with the oldest expectation
  task check_reply(status_e st, slot_t s, gen_t g, slot_t lv);
    res_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("result word with nothing expected (status %0d)", st));
      return;
    end
    want = expected_q.pop_front();
    if (st !== want.status)
      report($sformatf("status got %0d expected %0d", st, want.status));
    if (s !== want.slot)
      report($sformatf("slot got %0d expected %0d", s, want.slot));
    if (g !== want.gen)
      report($sformatf("gen got %0d expected %0d", g, want.gen));
    if (lv !== want.live)
      report($sformatf("live count got %0d expected %0d", lv, want.live));
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [1:0]  s_user  = '0;
  logic [71:0] s_data  = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [1:0]  m_user;
  logic [31:0] m_data;

  int send_idle_pct = 0;
  int stall_pct     = 0;

  slot_table_sb sb = new();

  generational_slot_allocator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tuser_i  (s_user),  // kind
    .s_axis_tdata_i  (s_data),  // slot_in, gen_in, ip_addr, port_num, pad
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tuser_o  (m_user),  // status
    .m_axis_tdata_o  (m_data)   // slot_out, gen_out, live_count, pad
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver stalls
  always @(negedge clk_i) begin
    m_ready <= ($urandom_range(99) >= stall_pct);
  end

  // result words
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready)
      sb.check_reply(status_e'(m_user), m_data[6:0], m_data[22:7], m_data[29:23]);
  end

  // drive one request word and wait for its handshake
  task automatic send_word(kind_e k, slot_t s, gen_t g, logic [31:0] ip,
                           logic [15:0] port);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= k;
    s_data  <= {1'b0, port, ip, g, s};
    do @(posedge clk_i); while (!s_ready);
    sb.note_request(k, s, g, ip, port);
  endtask

  // hold the sender off until every result word is back
  task automatic drain();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_live();
    int list [$];
    for (int i = 1; i < SlotCount; i++)
      if (sb.busy[i]) list.push_back(i);
    if (list.size() == 0) return 0;
    return list[$urandom_range(list.size() - 1)];
  endfunction

  // one random request, mostly aimed at live handles and stored keys
  task automatic random_word(int alloc_pct);
    int          r;
    int          s;
    kind_e       k;
    slot_t       sl;
    gen_t        g;
    logic [31:0] ip;
    logic [15:0] port;
    r    = $urandom_range(99);
    s    = pick_live();
    sl   = slot_t'($urandom_range(SlotCount - 1));
    g    = gen_t'($urandom_range(65535));
    ip   = $urandom;
    port = 16'($urandom_range(65535));
    if (r < alloc_pct) begin
      k = KIND_ALLOC;
      // duplicate keys now and then so find has to pick the lowest slot
      if (s != 0 && $urandom_range(3) == 0) begin
        ip   = sb.ip_of[s];
        port = sb.port_of[s];
      end
    end else begin
      case (r % 3)
        0:       k = KIND_RELEASE;
        1:       k = KIND_CHECK;
        default: k = KIND_FIND;
      endcase
      if (k == KIND_FIND) begin
        r = $urandom_range(9);
        if (r < 6 && s != 0) begin
          ip   = sb.ip_of[s];
          port = sb.port_of[s];
        end else if (r < 8) begin
          ip   = sb.ip_of[sl];
          port = sb.port_of[sl];
        end
      end else if (s != 0 && $urandom_range(3) != 0) begin
        sl = slot_t'(s);
        g  = sb.gen_of[s];
      end else begin
        case ($urandom_range(3))
          0: if (s != 0) begin
            sl = slot_t'(s);
            g  = sb.gen_of[s] + 1'b1;
          end
          1: sl = SlotNil;
          2: g = sb.gen_of[sl];
          default: ;
        endcase
      end
    end
    send_word(k, sl, g, ip, port);
  endtask

  task automatic random_phase(int idle_pct, int stall, int alloc_pct, int count);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (count) random_word(alloc_pct);
    drain();
  endtask

  // stimulus
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, extreme keys, stale handles, lifo reuse
    send_word(KIND_FIND,    SlotNil, 16'h0000, 32'h0000_0000, 16'h0000);
    send_word(KIND_CHECK,   SlotNil, 16'h0000, 32'h0000_0000, 16'h0000);
    send_word(KIND_RELEASE, SlotMax, 16'hffff, 32'hffff_ffff, 16'hffff);
    send_word(KIND_ALLOC,   SlotNil, 16'h0000, 32'h0000_0000, 16'h0000);
    send_word(KIND_ALLOC,   SlotMax, 16'hffff, 32'hffff_ffff, 16'hffff);
    send_word(KIND_CHECK,   7'd1,    16'd1,    32'h0000_0000, 16'h0000);
    send_word(KIND_CHECK,   7'd2,    16'hffff, 32'h0000_0000, 16'h0000);
    send_word(KIND_FIND,    SlotNil, 16'h0000, 32'h0000_0000, 16'h0000);
    send_word(KIND_FIND,    SlotNil, 16'h0000, 32'hffff_ffff, 16'hffff);
    send_word(KIND_FIND,    SlotNil, 16'h0000, 32'hffff_ffff, 16'h0000);
    send_word(KIND_RELEASE, 7'd1,    16'd1,    32'h0000_0000, 16'h0000);
    send_word(KIND_RELEASE, 7'd1,    16'd1,    32'h0000_0000, 16'h0000);
    send_word(KIND_CHECK,   7'd1,    16'd1,    32'h0000_0000, 16'h0000);
    send_word(KIND_ALLOC,   SlotNil, 16'h0000, 32'hffff_ffff, 16'hffff);
    send_word(KIND_FIND,    SlotNil, 16'h0000, 32'hffff_ffff, 16'hffff);
    send_word(KIND_RELEASE, 7'd2,    16'd1,    32'h0000_0000, 16'h0000);
    send_word(KIND_RELEASE, 7'd1,    16'd2,    32'h0000_0000, 16'h0000);
    send_word(KIND_ALLOC,   SlotNil, 16'h0000, 32'h0a00_0001, 16'd80);
    send_word(KIND_ALLOC,   SlotNil, 16'h0000, 32'hc0a8_0001, 16'd443);
    send_word(KIND_CHECK,   SlotMax, 16'h0000, 32'h0000_0000, 16'h0000);

    // fill the table, then push past full
    while (sb.live != SlotMax)
      send_word(KIND_ALLOC, SlotNil, '0, $urandom, 16'($urandom_range(65535)));
    repeat (3) send_word(KIND_ALLOC, SlotNil, '0, $urandom, 16'($urandom_range(65535)));
    send_word(KIND_CHECK, SlotMax, sb.gen_of[SlotMax], 32'h0, 16'h0);
    send_word(KIND_FIND, SlotNil, '0, sb.ip_of[SlotMax], sb.port_of[SlotMax]);
    send_word(KIND_FIND, SlotNil, '0, $urandom, 16'($urandom_range(65535)));
    drain();

    // empty it again
    for (int i = 1; i < SlotCount; i++)
      send_word(KIND_RELEASE, slot_t'(i), sb.gen_of[i], $urandom, 16'h0);

    // cycle one slot through a few generations
    for (int i = 0; i < 8; i++) begin
      send_word(KIND_ALLOC, SlotNil, '0, $urandom, 16'($urandom_range(65535)));
      if (sb.last.status == STAT_OK)
        send_word(KIND_RELEASE, sb.last.slot, sb.last.gen, 32'h0, 16'h0);
    end
    drain();

    // random traffic under each idling pattern
    random_phase(0,  0,  55, 25);
    random_phase(83, 0,  30, 25);
    random_phase(0,  83, 45, 25);
    random_phase(30, 30, 25, 25);

    repeat (140) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d result words never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

`default_nettype wire
